// ===== rtl/weighted_key_stable_sorter_defines.svh =====
// Assertion macros for the weighted key sorter checker.
`ifndef WEIGHTED_KEY_STABLE_SORTER_DEFINES_SVH
`define WEIGHTED_KEY_STABLE_SORTER_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define WKSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define WKSS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/wkss_pkg.sv =====
// Types and constants of the weighted key stable sorter.
package wkss_pkg;

   localparam int VALUE_W  = 32;
   localparam int WEIGHT_W = 4;

   // weight contributions
   localparam logic [WEIGHT_W-1:0] W_SQUARE = 4'd5;
   localparam logic [WEIGHT_W-1:0] W_DIV46  = 4'd4;
   localparam logic [WEIGHT_W-1:0] W_EVEN   = 4'd3;

   // square root: one result bit per step from two input bits, over 32 input bits
   localparam int SQRT_STEPS = 16;
   localparam int STEP_W     = 4;
   localparam logic [VALUE_W-1:0] SQRT_FIRST_BIT = 32'h4000_0000;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [WEIGHT_W-1:0]       weight;
   } entry_type;

endpackage

// ===== rtl/weighted_key_stable_sorter.sv =====
// Top level of the weighted key stable sorter.
//
// Input channel (req_*): one signed 32-bit value per transfer; req_last_in
// closes the set. Result channel (rsp_*): on the closing item the stored
// pairs come out one transfer each, heaviest weight first, equal weights in
// arrival order; rsp_last_out marks the final one, rsp_overflow is set on
// every result of a set that had more than MAX_ITEMS items.
// Weight: +5 for a non-negative perfect square, +4 when the magnitude is a
// multiple of 4 or 6, +3 when it is even.
// Per item: S_IDLE takes it, S_WEIGH runs the bit-pair square root (mod 3
// runs alongside), then the stable insertion into the entry memory takes
// an S_INS_RD and an S_INS_CHK per stored entry compared (read, then
// compare and write back), plus a final S_INS_RD when the item lands at
// the top. Dropped items (store full) are handled in S_IDLE alone.
// Readout: each result passes through memory read, load and transfer
// states; a stall simply holds the result register.
// req_ready is high only while no item or readout is in flight.
// Reset empties the store (count and overflow cleared); memory contents
// need no clearing since only entries below the count are ever read.
module weighted_key_stable_sorter #(
   parameter int MAX_ITEMS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [wkss_pkg::VALUE_W-1:0]   req_value,
   input  logic                                  req_last_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [wkss_pkg::VALUE_W-1:0]   rsp_element,
   output logic [wkss_pkg::WEIGHT_W-1:0]         rsp_weight,
   output logic                                  rsp_last_out,
   output logic                                  rsp_overflow
);
   import wkss_pkg::*;

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_WEIGH    = 3'd1;
   localparam logic [2:0] S_INS_RD   = 3'd2;
   localparam logic [2:0] S_INS_CHK  = 3'd3;
   localparam logic [2:0] S_OUT_RD   = 3'd4;
   localparam logic [2:0] S_OUT_LD   = 3'd5;
   localparam logic [2:0] S_OUT_WAIT = 3'd6;

   // entry memory, one write and one registered read per cycle
   entry_type mem [MAX_ITEMS];
   entry_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;

   // control
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // item being weighed
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      last_ff, last_in;
   logic                      neg_ff, neg_in;
   logic [VALUE_W-1:0]        mag_ff, mag_in;
   logic [VALUE_W-1:0]        rem_ff, rem_in;
   logic [VALUE_W-1:0]        root_ff, root_in;
   logic [VALUE_W-1:0]        bit_ff, bit_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [1:0]                mod3_ff, mod3_in;
   logic [WEIGHT_W-1:0]       w_ff, w_in;

   // result register
   logic signed [VALUE_W-1:0] element_ff, element_in;
   logic [WEIGHT_W-1:0]       oweight_ff, oweight_in;
   logic                      olast_ff, olast_in;
   logic                      oovf_ff, oovf_in;

   logic [VALUE_W-1:0] raw;
   logic [VALUE_W-1:0] trial;
   logic [1:0]         digit;
   logic [2:0]         sum3;
   logic               is_square;
   logic               div4;
   logic               div6;
   logic               even;
   entry_type          new_entry;

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_element  = element_ff;
   assign rsp_weight   = oweight_ff;
   assign rsp_last_out = olast_ff;
   assign rsp_overflow = oovf_ff;

   assign raw       = req_value;
   assign new_entry = '{value: value_ff, weight: w_ff};

   // one bit-pair step of the restoring square root
   assign trial = root_ff + bit_ff;
   // mod 3 as the sum of base-4 digits, one digit per step
   assign digit = mag_ff[2*step_ff +: 2];
   assign sum3  = {1'b0, mod3_ff} + {1'b0, digit};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      step_in      = step_ff;
      mod3_in      = mod3_ff;
      w_in         = w_ff;
      element_in   = element_ff;
      oweight_in   = oweight_ff;
      olast_in     = olast_ff;
      oovf_in      = oovf_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = new_entry;
      rd_addr      = (state_ff == S_OUT_RD) ? idx_ff : (pos_ff - AW'(1));
      is_square    = 1'b0;
      div4         = 1'b0;
      div6         = 1'b0;
      even         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in = req_last_in;
               idx_in  = '0;
               if (count_ff == CW'(MAX_ITEMS)) begin
                  // store full: drop, but still flush on the closing item
                  ovf_in   = 1'b1;
                  state_in = req_last_in ? S_OUT_RD : S_IDLE;
               end else begin
                  value_in = req_value;
                  neg_in   = raw[VALUE_W-1];
                  mag_in   = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
                  rem_in   = raw;
                  root_in  = '0;
                  bit_in   = SQRT_FIRST_BIT;
                  step_in  = '0;
                  mod3_in  = '0;
                  state_in = S_WEIGH;
               end
            end
         end
         S_WEIGH: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            mod3_in = (sum3 >= 3'd3) ? 2'(sum3 - 3'd3) : sum3[1:0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               // zero remainder after the last step means an exact square
               is_square = !neg_ff && (rem_in == '0);
               even      = !mag_ff[0];
               div4      = (mag_ff[1:0] == 2'b00);
               div6      = even && (mod3_in == 2'd0);
               w_in      = (is_square ? W_SQUARE : '0)
                         + ((div4 || div6) ? W_DIV46 : '0)
                         + (even ? W_EVEN : '0);
               pos_in    = count_ff[AW-1:0];
               state_in  = S_INS_RD;
            end
         end
         S_INS_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = last_ff ? S_OUT_RD : S_IDLE;
            end else begin
               state_in = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            wr_en = 1'b1;
            if (rd_data_ff.weight < w_ff) begin
               // lighter entry moves down one place
               wr_data  = rd_data_ff;
               pos_in   = pos_ff - AW'(1);
               state_in = S_INS_RD;
            end else begin
               count_in = count_ff + CW'(1);
               state_in = last_ff ? S_OUT_RD : S_IDLE;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            element_in   = rd_data_ff.value;
            oweight_in   = rd_data_ff.weight;
            olast_in     = ((CW'(idx_ff) + CW'(1)) == count_ff);
            oovf_in      = ovf_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (olast_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      value_ff   <= value_in;
      last_ff    <= last_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      bit_ff     <= bit_in;
      step_ff    <= step_in;
      mod3_ff    <= mod3_in;
      w_ff       <= w_in;
      element_ff <= element_in;
      oweight_ff <= oweight_in;
      olast_ff   <= olast_in;
      oovf_ff    <= oovf_in;
   end

endmodule

// ===== rtl/wkss_checker.sv =====
// Port-level checker for the weighted key stable sorter, with its bind.
`include "weighted_key_stable_sorter_defines.svh"

module wkss_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic signed [wkss_pkg::VALUE_W-1:0] req_value,
   input logic                                req_last_in,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [wkss_pkg::VALUE_W-1:0] rsp_element,
   input logic [wkss_pkg::WEIGHT_W-1:0]       rsp_weight,
   input logic                                rsp_last_out,
   input logic                                rsp_overflow
);
   import wkss_pkg::*;

   // track the run being emitted
   logic                in_run_ff;
   logic [WEIGHT_W-1:0] prev_w_ff;
   logic                prev_ovf_ff;
   logic                rsp_xfer;
   logic                weight_ok;

   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign weight_ok = (rsp_weight == 4'd0) || (rsp_weight == 4'd3) || (rsp_weight == 4'd5)
                   || (rsp_weight == 4'd7) || (rsp_weight == 4'd8) || (rsp_weight == 4'd12);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
      end else if (rsp_xfer) begin
         in_run_ff <= !rsp_last_out;
      end
      if (rsp_xfer) begin
         prev_w_ff   <= rsp_weight;
         prev_ovf_ff <= rsp_overflow;
      end
   end

   `WKSS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element) && $stable(rsp_weight) && $stable(rsp_last_out), "result changed while stalled")
   `WKSS_ASSERT(a_weight_set, clock, reset, rsp_valid |-> weight_ok, "impossible weight value")
   `WKSS_ASSERT(a_descending, clock, reset, rsp_valid && in_run_ff |-> rsp_weight <= prev_w_ff && rsp_overflow == prev_ovf_ff, "run not descending or overflow changed")
   `WKSS_ASSERT_NEVER(a_no_take_in_run, clock, reset, req_ready && (rsp_valid || in_run_ff), "input taken during readout")

endmodule

bind weighted_key_stable_sorter wkss_checker u_wkss_checker (.*);

// ===== verif/tb_weighted_key_stable_sorter.sv =====
// Testbench for the weighted key stable sorter: random and directed sets checked by a scoreboard.
module tb_weighted_key_stable_sorter;
   timeunit 1ns;
   timeprecision 1ps;

   import wkss_pkg::*;

   localparam int DEPTH        = 16;      // store depth, matches the DUT default
   localparam int RANDOM_ITEMS = 70;      // stored items in the random part
   localparam int QUIET_ITEMS  = 20;      // tail of the run with no idling
   localparam int LONG_STALL   = 400;     // receiver hold-off, in cycles
   localparam int DRAIN_CYCLES = 60;      // longer than a worst-case insertion
   localparam int CYCLE_LIMIT  = 200000;

   // one sorted output transfer
   typedef struct packed {
      logic signed [VALUE_W-1:0] element;
      logic [WEIGHT_W-1:0]       weight;
      logic                      last_out;
      logic                      overflow;
   } sorted_result_type;

   // Mirrors the store: keeps the pairs in weight order as they arrive and
   // queues the whole ordered set when the closing item comes in.
   class sort_scoreboard;
      entry_type         sorted_pairs[$];
      sorted_result_type expected_results[$];
      logic              dropped_flag;
      int unsigned       errors;

      function new();
         dropped_flag = 1'b0;
         errors = 0;
      endfunction

      // floor square root by binary search on the root bits, then weight
      function logic [WEIGHT_W-1:0] weigh_value(logic signed [VALUE_W-1:0] v);
         logic [VALUE_W-1:0] mag;
         logic [63:0]        root;
         logic [63:0]        cand;
         logic [WEIGHT_W-1:0] w;
         mag  = v[VALUE_W-1] ? (32'd0 - v) : v;
         root = '0;
         w    = '0;
         for (int b = 15; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= {32'd0, v}) root = cand;
         end
         if (!v[VALUE_W-1] && root * root == {32'd0, v}) w = W_SQUARE;
         if (mag % 4 == 0 || mag % 6 == 0) w = w + W_DIV46;
         if (mag % 2 == 0) w = w + W_EVEN;
         return w;
      endfunction

      function void note_item(logic signed [VALUE_W-1:0] v, logic last);
         entry_type         e;
         sorted_result_type r;
         int                pos;
         if (sorted_pairs.size() < DEPTH) begin
            e.value  = v;
            e.weight = weigh_value(v);
            // stable: new pair goes behind every pair of equal or higher weight
            pos = sorted_pairs.size();
            while (pos > 0 && sorted_pairs[pos-1].weight < e.weight) pos--;
            sorted_pairs.insert(pos, e);
         end else begin
            dropped_flag = 1'b1;
         end
         if (last) begin
            foreach (sorted_pairs[i]) begin
               r.element  = sorted_pairs[i].value;
               r.weight   = sorted_pairs[i].weight;
               r.last_out = (i == sorted_pairs.size() - 1);
               r.overflow = dropped_flag;
               expected_results.push_back(r);
            end
            sorted_pairs.delete();
            dropped_flag = 1'b0;
         end
      endfunction

      function void check_result(sorted_result_type got);
         sorted_result_type exp_r;
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: element %0d weight %0d last %0b ovf %0b",
                        got.element, got.weight, got.last_out, got.overflow);
            return;
         end
         exp_r = expected_results.pop_front();
         if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp element %0d weight %0d last %0b ovf %0b, got %0d %0d %0b %0b",
                        exp_r.element, exp_r.weight, exp_r.last_out, exp_r.overflow,
                        got.element, got.weight, got.last_out, got.overflow);
         end
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_value   = '0;
   logic                      req_last_in = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   logic signed [VALUE_W-1:0] rsp_element;
   logic [WEIGHT_W-1:0]       rsp_weight;
   logic                      rsp_last_out;
   logic                      rsp_overflow;

   sort_scoreboard sb = new();

   // run control shared by the sender and the receiver, and the watchdog cycle count
   bit          quiet_phase    = 1'b0;   // no idling on either side
   bit          long_stall_req = 1'b0;   // sender asks the receiver to hold off
   int unsigned cycle_count    = 0;

   weighted_key_stable_sorter #(.MAX_ITEMS(DEPTH)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_element  (rsp_element),
      .rsp_weight   (rsp_weight),
      .rsp_last_out (rsp_last_out),
      .rsp_overflow (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[weighted_key_stable_sorter] ERROR");
         $finish;
      end
   end

   // Result monitor. Sampling at the edge sees the pre-edge values of both
   // the DUT outputs and our own nonblocking-driven rsp_ready.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(sorted_result_type'{rsp_element, rsp_weight,
                                             rsp_last_out, rsp_overflow});
   end

   // Receiver: per-cycle decision with a stall countdown. Random hold-offs,
   // plus one long hold-off on request so the DUT backs up and drops
   // req_ready while the sender keeps offering.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left = LONG_STALL;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (quiet_phase || $urandom_range(0, 15) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_ready <= 1'b0;
         end
      end
   end

   // Value mix: full range, perfect squares, small signed, signed multiples of
   // 4 / 6, and the range ends.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int unsigned root;
      case ($urandom_range(0, 5))
         0, 1: pick_value = $urandom;
         2: begin
            root = $urandom_range(0, 46340);
            pick_value = root * root;
         end
         3: pick_value = $signed($urandom_range(0, 128)) - 64;
         4: pick_value = ($urandom_range(0, 1) ? 4 : 6)
                         * ($signed($urandom_range(0, 2000000)) - 1000000);
         default: begin
            case ($urandom_range(0, 3))
               0: pick_value = 32'sh7FFF_FFFF;
               1: pick_value = 32'sh8000_0000;
               2: pick_value = 32'sd2147395600;   // largest 32-bit square
               default: pick_value = -32'sd1;
            endcase
         end
      endcase
   endfunction

   // Offer one item and hold it until the transfer; valid stays high on return.
   task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic last);
      req_valid   <= 1'b1;
      req_value   <= v;
      req_last_in <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(v, last);
   endtask

   // Random sender gap outside the quiet tail.
   task automatic maybe_idle();
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Stop offering until every queued result has been seen.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   logic signed [VALUE_W-1:0] edge_values[8] = '{
      32'sd0, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
      -32'sd6, 32'sd2147395600, 32'sd3, 32'sd6
   };

   initial begin
      int unsigned stored_items;
      int unsigned set_idx;
      int unsigned set_len;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: range ends, zero, negative multiple of 6, largest square,
      // odd non-square, ties in weight -- one set closed by its last value.
      foreach (edge_values[i]) begin
         maybe_idle();
         send_item(edge_values[i], i == 7);
      end
      // one-item set
      maybe_idle();
      send_item(-32'sd4, 1'b1);
      // store full: 16 stored, the closing item is dropped and overflow set
      for (int i = 0; i <= DEPTH; i++) begin
         maybe_idle();
         send_item(pick_value(), i == DEPTH);
      end

      // Random sets, mostly within depth, some overflowing.
      stored_items = 0;
      set_idx = 0;
      while (stored_items < RANDOM_ITEMS) begin
         set_len = ($urandom_range(0, 5) == 0) ? $urandom_range(DEPTH + 1, DEPTH + 4)
                                               : $urandom_range(1, DEPTH);
         if (set_idx == 2) set_len = DEPTH;
         // sender holds back once until the output side has fully drained
         if (set_idx == 4) wait_drained();
         for (int i = 0; i < set_len; i++) begin
            if (stored_items >= RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
            // long receiver hold-off right as a full set closes; the next set
            // keeps pushing against a blocked input
            if (set_idx == 2 && i == set_len - 1) long_stall_req = 1'b1;
            maybe_idle();
            send_item(pick_value(), i == set_len - 1);
            if (i < DEPTH) stored_items++;
         end
         set_idx++;
      end

      // Drain, then allow one worst-case insertion for any stray output.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[weighted_key_stable_sorter] OK");
      end else begin
         $display("[weighted_key_stable_sorter] ERROR");
      end
      $finish;
   end

endmodule
